>>> rtl/infix_to_postfix_converter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define ITP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp check failed");

// Next-cycle implication, also checked while reset is applied.
`define ITP_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("itp check failed");

`endif

>>> rtl/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and lookup functions of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Default operator stack depth and depth of the front-to-back queue
  localparam int ITP_STACK_DEPTH = 32;
  localparam int ITP_QUEUE_DEPTH = 4;

  // ASCII characters with a role of their own
  localparam logic [7:0] ITP_CH_NUL   = 8'h00;
  localparam logic [7:0] ITP_CH_OPEN  = 8'h28;
  localparam logic [7:0] ITP_CH_CLOSE = 8'h29;
  localparam logic [7:0] ITP_CH_MUL   = 8'h2A;
  localparam logic [7:0] ITP_CH_ADD   = 8'h2B;
  localparam logic [7:0] ITP_CH_SUB   = 8'h2D;
  localparam logic [7:0] ITP_CH_DIV   = 8'h2F;

  // Stack entry codes
  typedef logic [2:0] itp_code_t;
  localparam itp_code_t ITP_CODE_OPEN = 3'd0;
  localparam itp_code_t ITP_CODE_ADD  = 3'd1;
  localparam itp_code_t ITP_CODE_SUB  = 3'd2;
  localparam itp_code_t ITP_CODE_MUL  = 3'd3;
  localparam itp_code_t ITP_CODE_DIV  = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ITP_ST_OK        = 2'd0,
    ITP_ST_UNKNOWN   = 2'd1,
    ITP_ST_UNMATCHED = 2'd2,
    ITP_ST_OVERFLOW  = 2'd3
  } itp_status_t;

  // Character classes found by the front end
  typedef enum logic [2:0] {
    ITP_K_END,
    ITP_K_ALNUM,
    ITP_K_OPEN,
    ITP_K_CLOSE,
    ITP_K_OP,
    ITP_K_UNKNOWN
  } itp_kind_t;

  // Back-end engine state
  typedef enum logic {
    ITP_ENG_IDLE,
    ITP_ENG_BUSY
  } itp_eng_state_t;

  // One classified character
  typedef struct packed {
    logic [7:0] symbol;
    itp_kind_t  kind;
    itp_code_t  code;
  } itp_item_t;

  // Operator priority; a stacked '(' has the lowest
  function automatic logic [3:0] itp_prio(input itp_code_t code);
    logic [3:0] p;
    case (code)
      ITP_CODE_ADD, ITP_CODE_SUB: p = 4'd7;
      ITP_CODE_MUL, ITP_CODE_DIV: p = 4'd8;
      default:                    p = 4'd0;
    endcase
    return p;
  endfunction

  // Character written out for a stack entry
  function automatic logic [7:0] itp_code_char(input itp_code_t code);
    logic [7:0] c;
    case (code)
      ITP_CODE_ADD: c = ITP_CH_ADD;
      ITP_CODE_SUB: c = ITP_CH_SUB;
      ITP_CODE_MUL: c = ITP_CH_MUL;
      ITP_CODE_DIV: c = ITP_CH_DIV;
      default:      c = ITP_CH_OPEN;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/itp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_front
// Input stage: takes characters, classifies them and holds one for the queue.
// ----------------------------------------------------------------------------
module itp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_symbol,
  output logic             q_valid,
  input  logic             q_ready,
  output itp_pkg::itp_item_t q_item
);
  import itp_pkg::*;

  logic      hold_valid_r;
  itp_item_t hold_item_r;
  itp_item_t class_item;
  logic      in_xfer;

  // Classify the incoming character
  always_comb begin
    class_item.symbol = in_symbol;
    class_item.code   = ITP_CODE_OPEN;
    case (in_symbol) inside
      ITP_CH_NUL:   class_item.kind = ITP_K_END;
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]:
                    class_item.kind = ITP_K_ALNUM;
      ITP_CH_OPEN:  class_item.kind = ITP_K_OPEN;
      ITP_CH_CLOSE: class_item.kind = ITP_K_CLOSE;
      ITP_CH_ADD: begin
        class_item.kind = ITP_K_OP;
        class_item.code = ITP_CODE_ADD;
      end
      ITP_CH_SUB: begin
        class_item.kind = ITP_K_OP;
        class_item.code = ITP_CODE_SUB;
      end
      ITP_CH_MUL: begin
        class_item.kind = ITP_K_OP;
        class_item.code = ITP_CODE_MUL;
      end
      ITP_CH_DIV: begin
        class_item.kind = ITP_K_OP;
        class_item.code = ITP_CODE_DIV;
      end
      default:      class_item.kind = ITP_K_UNKNOWN;
    endcase
  end

  assign in_ready = !hold_valid_r || q_ready;
  assign in_xfer  = in_valid && in_ready;
  assign q_valid  = hold_valid_r;
  assign q_item   = hold_item_r;

  // Holding register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_xfer) begin
      hold_valid_r <= 1'b1;
    end else if (q_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  // Holding register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_item_r <= class_item;
    end
  end

endmodule

>>> rtl/itp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_queue
// Short FIFO of classified characters between front end and stack engine.
// ----------------------------------------------------------------------------
module itp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  itp_pkg::itp_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output itp_pkg::itp_item_t rd_item
);
  import itp_pkg::*;

  localparam int PTR_W = (ITP_QUEUE_DEPTH > 1) ? $clog2(ITP_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ITP_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ITP_QUEUE_DEPTH - 1);

  itp_item_t        entry_r [ITP_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             wr_xfer;
  logic             rd_xfer;

  assign wr_ready = (fill_r != CNT_W'(ITP_QUEUE_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign wr_xfer  = wr_valid && wr_ready;
  assign rd_xfer  = rd_valid && rd_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_xfer) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_xfer) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr_xfer, rd_xfer})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_xfer) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> rtl/itp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_engine
// Operator stack engine: pushes, pops and writes at most one result a cycle, none while the result side stalls.
// ----------------------------------------------------------------------------
module itp_engine #(
  parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  itp_pkg::itp_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_symbol,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import itp_pkg::*;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  // Stack memory; top entry also mirrored in top_r, the one below in below_q
  itp_code_t stack_mem [STACK_DEPTH];

  itp_eng_state_t   state_r, state_nxt;
  itp_item_t        cur_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] open_cnt_r, open_cnt_nxt;
  itp_code_t        top_r, top_nxt;
  itp_code_t        below_q;
  logic [CNT_W-1:0] below_idx;
  logic [ADDR_W-1:0] rd_addr;

  logic             out_valid_r;
  logic [7:0]       out_symbol_r;
  itp_status_t      out_status_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  logic [7:0]       emit_sym;
  itp_status_t      emit_st;
  logic             emit_last;
  logic             do_push;
  logic             do_pop;
  logic             done;
  logic             take;
  logic             stack_empty;
  logic             stack_full;

  assign out_free    = !out_valid_r || out_ready;
  assign stack_empty = (count_r == '0);
  assign stack_full  = (count_r == FULL_CNT);

  // Actions for the character being worked on
  always_comb begin
    emit      = 1'b0;
    emit_sym  = cur_r.symbol;
    emit_st   = ITP_ST_OK;
    emit_last = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    done      = 1'b0;
    if (state_r == ITP_ENG_BUSY) begin
      case (cur_r.kind)
        ITP_K_END: begin
          emit = 1'b1;
          if (!stack_empty) begin
            emit_sym = itp_code_char(top_r);
            do_pop   = out_free;
          end else begin
            emit_sym  = ITP_CH_NUL;
            emit_last = 1'b1;
            done      = out_free;
          end
        end
        ITP_K_ALNUM: begin
          emit = 1'b1;
          done = out_free;
        end
        ITP_K_OPEN: begin
          if (stack_full) begin
            emit    = 1'b1;
            emit_st = ITP_ST_OVERFLOW;
            done    = out_free;
          end else begin
            do_push = 1'b1;
            done    = 1'b1;
          end
        end
        ITP_K_CLOSE: begin
          if (open_cnt_r == '0) begin
            emit    = 1'b1;
            emit_st = ITP_ST_UNMATCHED;
            done    = out_free;
          end else if (top_r != ITP_CODE_OPEN) begin
            emit     = 1'b1;
            emit_sym = itp_code_char(top_r);
            do_pop   = out_free;
          end else begin
            // matching '(' is dropped
            do_pop = 1'b1;
            done   = 1'b1;
          end
        end
        ITP_K_OP: begin
          if (!stack_empty && (itp_prio(top_r) >= itp_prio(cur_r.code))) begin
            emit     = 1'b1;
            emit_sym = itp_code_char(top_r);
            do_pop   = out_free;
          end else if (stack_full) begin
            emit    = 1'b1;
            emit_st = ITP_ST_OVERFLOW;
            done    = out_free;
          end else begin
            do_push = 1'b1;
            done    = 1'b1;
          end
        end
        default: begin
          emit    = 1'b1;
          emit_st = ITP_ST_UNKNOWN;
          done    = out_free;
        end
      endcase
    end
  end

  // Next state: fetch a new character when idle or when the current one ends
  assign take    = (state_r == ITP_ENG_IDLE) || done;
  assign q_ready = take;

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      state_nxt = q_valid ? ITP_ENG_BUSY : ITP_ENG_IDLE;
    end
  end

  // Stack bookkeeping
  always_comb begin
    count_nxt    = count_r;
    open_cnt_nxt = open_cnt_r;
    top_nxt      = top_r;
    if (do_push) begin
      count_nxt = count_r + 1'b1;
      top_nxt   = (cur_r.kind == ITP_K_OPEN) ? ITP_CODE_OPEN : cur_r.code;
      if (cur_r.kind == ITP_K_OPEN) begin
        open_cnt_nxt = open_cnt_r + 1'b1;
      end
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
      top_nxt   = below_q;
      if (top_r == ITP_CODE_OPEN) begin
        open_cnt_nxt = open_cnt_r - 1'b1;
      end
    end
  end

  // Address the entry under the new top, so below_q holds it alongside top_r
  assign below_idx = count_nxt - CNT_W'(2);
  assign rd_addr   = (count_nxt >= CNT_W'(2)) ? below_idx[ADDR_W-1:0] : '0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ITP_ENG_IDLE;
      count_r     <= '0;
      open_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      open_cnt_r <= open_cnt_nxt;
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (take && q_valid) begin
      cur_r <= q_item;
    end
    if (emit && out_free) begin
      out_symbol_r <= emit_sym;
      out_status_r <= emit_st;
      out_last_r   <= emit_last;
    end
  end

  // Stack memory write and registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[count_r[ADDR_W-1:0]] <= top_nxt;
    end
    below_q <= stack_mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: one infix character in, postfix characters out.
// ----------------------------------------------------------------------------
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, in_symbol[7:0]         | in
//  result  | out_valid, out_ready, out_symbol[7:0],     | out
//          | out_status[1:0], out_last                  |
//
//  The stack engine handles one result, one push or one discarded '(' at a
//  time; an end-of-expression flush writes out every stacked entry, then
//  the end marker. A character passes the input register, the queue, the
//  engine and the output register on its way to a result.
//  Reset is synchronous and empties the stack, queue and output register;
//  no clearing pass is needed. A stall on the result side stops only the
//  engine; the queue keeps taking characters until it fills.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_defines.svh"

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic [1:0] out_status,
  output logic       out_last
);
  import itp_pkg::*;

  logic      fq_valid;
  logic      fq_ready;
  itp_item_t fq_item;
  logic      qe_valid;
  logic      qe_ready;
  itp_item_t qe_item;

  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  itp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qe_valid),
    .rd_ready (qe_ready),
    .rd_item  (qe_item)
  );

  itp_engine #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qe_valid),
    .q_ready    (qe_ready),
    .q_item     (qe_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // End marker is always a clean zero
`ITP_ASSERT_IMP(a_last_is_zero, clk, rst_n, out_valid && out_last, out_symbol == ITP_CH_NUL && out_status == ITP_ST_OK)
  // Unmatched status only ever carries ')'
`ITP_ASSERT_IMP(a_unmatched_sym, clk, rst_n, out_valid && out_status == ITP_ST_UNMATCHED, out_symbol == ITP_CH_CLOSE && !out_last)
  // Overflow only from '(' or an operator
`ITP_ASSERT_IMP(a_overflow_sym, clk, rst_n, out_valid && out_status == ITP_ST_OVERFLOW, out_symbol == ITP_CH_OPEN || out_symbol == ITP_CH_ADD || out_symbol == ITP_CH_SUB || out_symbol == ITP_CH_MUL || out_symbol == ITP_CH_DIV)
  // Reset leaves no result pending and the input open
`ITP_ASSERT_NXT(a_reset_clears, clk, !rst_n, !out_valid && in_ready)

endmodule

>>> dv/infix_to_postfix_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_checker
// Watches both channels of the converter. Each character transfer on the
// input side runs through a shunting-yard prediction that produces the
// expected postfix results. Each result transfer is compared field by field
// against the oldest expected one. A failure count and the number of results
// still due are handed back to the testbench top.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_checker #(
  parameter int STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_symbol,
  input  logic [1:0] out_status,
  input  logic       out_last,
  output int         fail_count,
  output int         results_due
);
  import itp_pkg::*;

  typedef struct {
    logic [7:0]  symbol;
    itp_status_t status;
    logic        last;
  } postfix_result_t;

  // Predicted operator stack
  itp_code_t       op_stack [STACK_DEPTH];
  int              op_depth;
  postfix_result_t postfix_due [$];
  int              mismatches;

  assign fail_count = mismatches;

  // Binding strength of a stacked entry; '(' binds weakest
  function automatic int op_rank(input itp_code_t code);
    case (code)
      ITP_CODE_ADD, ITP_CODE_SUB: return 7;
      ITP_CODE_MUL, ITP_CODE_DIV: return 8;
      default:                    return 0;
    endcase
  endfunction

  // Character written out when an entry leaves the stack
  function automatic logic [7:0] stacked_char(input itp_code_t code);
    case (code)
      ITP_CODE_ADD: return ITP_CH_ADD;
      ITP_CODE_SUB: return ITP_CH_SUB;
      ITP_CODE_MUL: return ITP_CH_MUL;
      ITP_CODE_DIV: return ITP_CH_DIV;
      default:      return ITP_CH_OPEN;
    endcase
  endfunction

  task automatic add_result(input logic [7:0] sym, input itp_status_t st, input logic lst);
    postfix_result_t r;
    r.symbol = sym;
    r.status = st;
    r.last   = lst;
    postfix_due.push_back(r);
  endtask

  task automatic pop_to_output();
    op_depth--;
    add_result(stacked_char(op_stack[op_depth]), ITP_ST_OK, 1'b0);
  endtask

  // One character through the shunting-yard
  task automatic convert_symbol(input logic [7:0] c);
    itp_code_t code;
    bit        is_op;
    bit        has_open;
    is_op    = 1'b1;
    has_open = 1'b0;
    case (c)
      ITP_CH_ADD: code = ITP_CODE_ADD;
      ITP_CH_SUB: code = ITP_CODE_SUB;
      ITP_CH_MUL: code = ITP_CODE_MUL;
      ITP_CH_DIV: code = ITP_CODE_DIV;
      default: begin
        code  = ITP_CODE_OPEN;
        is_op = 1'b0;
      end
    endcase

    if (c == ITP_CH_NUL) begin
      // end of expression: drain everything, leftover '(' included
      while (op_depth > 0) pop_to_output();
      add_result(ITP_CH_NUL, ITP_ST_OK, 1'b1);
    end else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                 (c >= "a" && c <= "z")) begin
      add_result(c, ITP_ST_OK, 1'b0);
    end else if (c == ITP_CH_OPEN) begin
      if (op_depth >= STACK_DEPTH) begin
        add_result(c, ITP_ST_OVERFLOW, 1'b0);
      end else begin
        op_stack[op_depth] = ITP_CODE_OPEN;
        op_depth++;
      end
    end else if (c == ITP_CH_CLOSE) begin
      for (int i = 0; i < op_depth; i++)
        if (op_stack[i] == ITP_CODE_OPEN) has_open = 1'b1;
      if (!has_open) begin
        add_result(c, ITP_ST_UNMATCHED, 1'b0);
      end else begin
        while (op_depth > 0 && op_stack[op_depth-1] != ITP_CODE_OPEN) pop_to_output();
        op_depth--;  // matching '(' is dropped
      end
    end else if (is_op) begin
      // left-associative: pop equal or stronger operators first
      while (op_depth > 0 && op_rank(op_stack[op_depth-1]) >= op_rank(code)) pop_to_output();
      if (op_depth >= STACK_DEPTH) begin
        add_result(c, ITP_ST_OVERFLOW, 1'b0);
      end else begin
        op_stack[op_depth] = code;
        op_depth++;
      end
    end else begin
      add_result(c, ITP_ST_UNKNOWN, 1'b0);
    end
  endtask

  initial begin
    op_depth   = 0;
    mismatches = 0;
    results_due = 0;
  end

  // Compare result transfers, then predict from input transfers
  always @(posedge clk) begin
    postfix_result_t exp_r;
    if (!rst_n) begin
      op_depth = 0;
      postfix_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (postfix_due.size() == 0) begin
          $error("unexpected result: out_symbol %0h out_status %0d out_last %0b",
                 out_symbol, out_status, out_last);
          mismatches++;
        end else begin
          exp_r = postfix_due.pop_front();
          if (out_symbol !== exp_r.symbol) begin
            $error("out_symbol: expected %0h, actual %0h", exp_r.symbol, out_symbol);
            mismatches++;
          end
          if (out_status !== exp_r.status) begin
            $error("out_status: expected %0d, actual %0d", exp_r.status, out_status);
            mismatches++;
          end
          if (out_last !== exp_r.last) begin
            $error("out_last: expected %0b, actual %0b", exp_r.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) convert_symbol(in_symbol);
    end
    results_due <= postfix_due.size();
  end

endmodule

>>> dv/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Drives infix character streams into the converter: a short directed set,
// then random expressions that are mostly well formed, with nesting deep
// enough to overflow the operator stack, stray characters and broken
// parentheses mixed in. Both sides idle in random bursts. The checker beside
// the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;
  import itp_pkg::*;

  localparam int DEPTH       = ITP_STACK_DEPTH;
  localparam int ITEM_TARGET = 420;
  localparam int QUIET_FROM  = 360;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_symbol;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_symbol;
  logic [1:0] out_status;
  logic       out_last;
  int         fail_count;
  int         results_due;

  logic [7:0] expr_chars [$];
  int         chars_sent;
  bit         quiet;  // last part of the run: no idling at all
  bit         calm;   // a stretch without idling

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  infix_to_postfix_converter_top #(.STACK_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_symbol (in_symbol),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_symbol(out_symbol),
    .out_status(out_status),
    .out_last  (out_last)
  );

  infix_to_postfix_converter_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_symbol  (in_symbol),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (out_last),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  // Result side: random stall bursts
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !quiet && !calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] random_alnum();
    logic [7:0] base;
    case ($urandom_range(0, 2))
      0: begin
        base = "0";
        return base + 8'($urandom_range(0, 9));
      end
      1: begin
        base = "A";
        return base + 8'($urandom_range(0, 25));
      end
      default: begin
        base = "a";
        return base + 8'($urandom_range(0, 25));
      end
    endcase
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return ITP_CH_ADD;
      1:       return ITP_CH_SUB;
      2:       return ITP_CH_MUL;
      default: return ITP_CH_DIV;
    endcase
  endfunction

  // One character transfer, optionally after an idle burst
  task automatic send_symbol(input logic [7:0] c);
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_chars[i]) send_symbol(expr_chars[i]);
  endtask

  // Hold the input side off until the converter has nothing left to deliver
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Well-formed expression with random content, sometimes broken
  task automatic build_expression();
    int open_cnt;
    int terms;
    bit want_operand;
    open_cnt     = 0;
    want_operand = 1'b1;
    terms        = $urandom_range(1, 12);
    expr_chars.delete();
    while (terms > 0 || want_operand) begin
      if (want_operand) begin
        if (open_cnt < 6 && $urandom_range(0, 3) == 0) begin
          expr_chars.push_back(ITP_CH_OPEN);
          open_cnt++;
        end else begin
          expr_chars.push_back(random_alnum());
          want_operand = 1'b0;
          terms--;
        end
      end else if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(ITP_CH_CLOSE);
        open_cnt--;
      end else begin
        expr_chars.push_back(random_operator());
        want_operand = 1'b1;
      end
    end
    // close the open '(' most of the time; otherwise the flush emits them
    if ($urandom_range(0, 4) != 0)
      repeat (open_cnt) expr_chars.push_back(ITP_CH_OPEN + 8'd1);
    // noise: a stray byte or a stray ')'
    if ($urandom_range(0, 7) == 0)
      expr_chars.insert($urandom_range(0, expr_chars.size()), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      expr_chars.insert($urandom_range(0, expr_chars.size()), ITP_CH_CLOSE);
    expr_chars.push_back(ITP_CH_NUL);
  endtask

  // Random bytes of any value, then end of expression
  task automatic build_noise();
    expr_chars.delete();
    repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(0, 255)));
    expr_chars.push_back(ITP_CH_NUL);
  endtask

  // Deep nesting of the given number of '(', near or past the stack depth
  task automatic build_deep(input int opens);
    expr_chars.delete();
    repeat (opens) expr_chars.push_back(ITP_CH_OPEN);
    expr_chars.push_back(random_alnum());
    expr_chars.push_back(ITP_CH_ADD);
    expr_chars.push_back(random_alnum());
    expr_chars.push_back(ITP_CH_MUL);
    expr_chars.push_back(random_alnum());
    expr_chars.push_back(ITP_CH_SUB);
    expr_chars.push_back(random_alnum());
    expr_chars.push_back(ITP_CH_CLOSE);
    expr_chars.push_back(ITP_CH_NUL);
  endtask

  // Stimulus
  initial begin
    logic [7:0] directed_chars [$];
    int         pick;
    directed_chars = '{ITP_CH_OPEN, "a", ITP_CH_SUB, "b", ITP_CH_CLOSE, ITP_CH_DIV, "9",
                       ITP_CH_MUL, "Z", ITP_CH_ADD, "z", ITP_CH_NUL,
                       ITP_CH_CLOSE, 8'hFF, 8'h80, "!", ITP_CH_OPEN, ITP_CH_OPEN,
                       "A", ITP_CH_MUL, "0", ITP_CH_NUL, ITP_CH_NUL};
    chars_sent = 0;
    quiet      = 1'b0;
    calm       = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_symbol <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operator, the special cases
    expr_chars = directed_chars;
    send_expression();
    drain_results();

    // random: two forced overflow cases first
    pick = 0;
    while (chars_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (pick == 0)
        build_deep(DEPTH - 1);
      else if (pick == 1)
        build_deep(DEPTH + 1);
      else if ($urandom_range(0, 24) == 0)
        build_deep($urandom_range(DEPTH - 4, DEPTH + 2));
      else if ($urandom_range(0, 9) == 0)
        build_noise();
      else
        build_expression();
      pick++;
      send_expression();
      if (chars_sent >= QUIET_FROM) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 14) == 0) drain_results();
    end

    // wait for the tail, then let the pipeline settle
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("infix_to_postfix_converter_top_tb: clean");
    else
      $display("infix_to_postfix_converter_top_tb: errors");
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("infix_to_postfix_converter_top_tb: errors");
    $finish;
  end

endmodule

>>> infix_to_postfix_converter_top.f
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_front.sv
rtl/itp_queue.sv
rtl/itp_engine.sv
rtl/infix_to_postfix_converter_top.sv
dv/infix_to_postfix_converter_checker.sv
dv/infix_to_postfix_converter_top_tb.sv
